// File: hw/rtl/spk_pkg.sv
// Shared constants, codes and record types for the shortest-palindrome block.
package spk_pkg;

  // String capacity and derived widths
  localparam int MAX_LEN  = 1024;
  localparam int FIELD_W  = 11;                    // width of index/length fields
  localparam int LEN_W    = $clog2(MAX_LEN + 1);   // holds 0..MAX_LEN
  localparam int TEXT_AW  = $clog2(MAX_LEN);       // text store address
  localparam int POS_W    = LEN_W + 1;             // holds 0..2*MAX_LEN
  localparam int PT_DEPTH = 2 * MAX_LEN + 1;       // prefix table depth

  // Command queue between front and back (depth must be a power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Input command field
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result kind field
  localparam logic KIND_LEN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Classified operations
  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD      = 2'd0;
  localparam op_t OP_LOAD_LAST = 2'd1;
  localparam op_t OP_READ      = 2'd2;

  typedef struct packed {
    op_t                op;
    logic [7:0]         char_in;
    logic [FIELD_W-1:0] read_index;
  } qentry_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         out_char;
    logic [FIELD_W-1:0] prefix_len;
    logic [FIELD_W-1:0] result_len;
    logic               overflow;
    logic               bad_index;
  } result_t;

endpackage

// File: hw/rtl/spk_queue.sv
// Small FIFO of classified requests between the front end and the engine.
module spk_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  spk_pkg::qentry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output spk_pkg::qentry_t head
);
  import spk_pkg::*;

  qentry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("request pushed into a full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("request popped from an empty queue");

endmodule

// File: hw/rtl/spk_engine.sv
// Back end: text and prefix-table memories, prefix-function sequencer, result register.
module spk_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  spk_pkg::qentry_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output spk_pkg::result_t out_data
);
  import spk_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_FALL  = 3'd3;
  localparam logic [2:0] S_RDATA = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  typedef struct packed {
    logic               sep;
    logic [TEXT_AW-1:0] addr;
  } sym_t;

  // Position p of s, separator, reverse(s) -> text address or separator mark
  function automatic sym_t sym_map(input logic [POS_W-1:0] p, input logic [LEN_W-1:0] n);
    sym_t             s;
    logic [POS_W-1:0] n_ext;
    logic [POS_W-1:0] mirror;
    n_ext  = POS_W'(n);
    mirror = {n, 1'b0} - p;
    s.sep  = (p == n_ext);
    if (p < n_ext) begin
      s.addr = p[TEXT_AW-1:0];
    end else begin
      s.addr = mirror[TEXT_AW-1:0];
    end
    return s;
  endfunction

  // Memories
  logic [7:0]       text_mem [MAX_LEN];
  logic [LEN_W-1:0] pt_mem   [PT_DEPTH];

  logic               tx_we;
  logic [TEXT_AW-1:0] tx_waddr;
  logic [7:0]         tx_wdata;
  logic [TEXT_AW-1:0] tx_raddr_a;
  logic [TEXT_AW-1:0] tx_raddr_b;
  logic [7:0]         tx_rdata_a;
  logic [7:0]         tx_rdata_b;
  logic               pt_we;
  logic [POS_W-1:0]   pt_waddr;
  logic [LEN_W-1:0]   pt_wdata;
  logic [POS_W-1:0]   pt_raddr;
  logic [LEN_W-1:0]   pt_rdata;

  // Control and string state
  logic [2:0]         state, state_next;
  logic [LEN_W-1:0]   n_q, n_next;
  logic [LEN_W-1:0]   pl_q, pl_next;
  logic               ovf_q, ovf_next;
  logic               computed_q, computed_next;
  logic [POS_W-1:0]   rlen_q, rlen_next;
  logic [LEN_W-1:0]   k_q, k_next;
  logic [POS_W-1:0]   i_q, i_next;
  logic [LEN_W-1:0]   len_q, len_next;
  logic               sep_a, sep_b;
  logic               res_kind, res_kind_next;
  logic               res_bad, res_bad_next;
  logic [7:0]         res_char, res_char_next;
  logic               out_valid_next;
  result_t            out_data_next;

  // Combinational helpers
  logic [POS_W-1:0]   pa;
  logic [POS_W-1:0]   pb;
  sym_t               sym_a;
  sym_t               sym_b;
  logic               read_mode;
  logic [POS_W-1:0]   rd_pos;
  logic [POS_W-1:0]   idx_ext;
  logic [POS_W-1:0]   k_ext;
  logic               sym_eq;
  logic [POS_W-1:0]   i_inc;
  logic               at_end;
  logic [LEN_W-1:0]   len_inc;
  logic [LEN_W-1:0]   n_base;
  logic [LEN_W-1:0]   fin_l;
  logic               finish;

  always_ff @(posedge clk) begin
    if (tx_we) begin
      text_mem[tx_waddr] <= tx_wdata;
    end
    tx_rdata_a <= text_mem[tx_raddr_a];
    tx_rdata_b <= text_mem[tx_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rdata <= pt_mem[pt_raddr];
  end

  // Shared address and compare logic
  assign sym_a      = sym_map(pa, n_q);
  assign sym_b      = sym_map(pb, n_q);
  assign read_mode  = (state == S_IDLE);
  assign tx_raddr_a = read_mode ? rd_pos[TEXT_AW-1:0] : sym_a.addr;
  assign tx_raddr_b = sym_b.addr;
  assign pt_raddr   = POS_W'(len_q - 1'b1);
  assign sym_eq     = (sep_a == sep_b) && (sep_a || (tx_rdata_a == tx_rdata_b));
  assign i_inc      = i_q + 1'b1;
  assign at_end     = (i_inc == {n_q, 1'b1});
  assign len_inc    = len_q + 1'b1;
  assign n_base     = computed_q ? '0 : n_q;

  // Read address: reversed tail first, then the string itself
  assign idx_ext = POS_W'(q_head.read_index);
  assign k_ext   = POS_W'(k_q);
  assign rd_pos  = (idx_ext < k_ext) ? (POS_W'(n_q) - 1'b1 - idx_ext) : (idx_ext - k_ext);

  // Separator marks are registered alongside the text read data, so they line up with it
  always_ff @(posedge clk) begin
    sep_a <= read_mode ? 1'b0 : sym_a.sep;
    sep_b <= sym_b.sep;
  end

  // Sequencer
  always_comb begin
    state_next     = state;
    n_next         = n_q;
    pl_next        = pl_q;
    ovf_next       = ovf_q;
    computed_next  = computed_q;
    rlen_next      = rlen_q;
    k_next         = k_q;
    i_next         = i_q;
    len_next       = len_q;
    res_kind_next  = res_kind;
    res_bad_next   = res_bad;
    res_char_next  = res_char;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    q_pop          = 1'b0;
    tx_we          = 1'b0;
    tx_waddr       = n_base[TEXT_AW-1:0];
    tx_wdata       = q_head.char_in;
    pt_we          = 1'b0;
    pt_waddr       = i_q;
    pt_wdata       = '0;
    pa             = i_q;
    pb             = POS_W'(len_q);
    finish         = 1'b0;
    fin_l          = '0;

    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_head.op)
            OP_READ: begin
              res_kind_next = KIND_READ;
              res_bad_next  = !(idx_ext < rlen_q);
              state_next    = S_RDATA;
            end
            OP_LOAD, OP_LOAD_LAST: begin
              // first byte after a finished string starts a new one
              if (computed_q) begin
                pl_next       = '0;
                ovf_next      = 1'b0;
                computed_next = 1'b0;
                rlen_next     = '0;
                k_next        = '0;
              end
              if (n_base == LEN_W'(MAX_LEN)) begin
                n_next   = n_base;
                ovf_next = 1'b1;
              end else begin
                tx_we  = 1'b1;
                n_next = n_base + 1'b1;
              end
              if (q_head.op == OP_LOAD_LAST) begin
                state_next = S_START;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_START: begin
        pt_we      = 1'b1;
        pt_waddr   = '0;
        pt_wdata   = '0;
        pa         = POS_W'(1);
        pb         = '0;
        i_next     = POS_W'(1);
        len_next   = '0;
        state_next = S_CMP;
      end

      S_CMP: begin
        if (sym_eq) begin
          pt_we    = 1'b1;
          pt_wdata = len_inc;
          if (at_end) begin
            finish = 1'b1;
            fin_l  = len_inc;
          end else begin
            pa       = i_inc;
            pb       = POS_W'(len_inc);
            i_next   = i_inc;
            len_next = len_inc;
          end
        end else if (len_q != '0) begin
          // fall back through the table, read issued this cycle
          state_next = S_FALL;
        end else begin
          pt_we    = 1'b1;
          pt_wdata = '0;
          if (at_end) begin
            finish = 1'b1;
          end else begin
            pa     = i_inc;
            pb     = '0;
            i_next = i_inc;
          end
        end
        if (finish) begin
          pl_next       = fin_l;
          computed_next = 1'b1;
          rlen_next     = {n_q, 1'b0} - POS_W'(fin_l);
          k_next        = n_q - fin_l;
          res_kind_next = KIND_LEN;
          res_bad_next  = 1'b0;
          res_char_next = '0;
          state_next    = S_EMIT;
        end
      end

      S_FALL: begin
        len_next   = pt_rdata;
        pa         = i_q;
        pb         = POS_W'(pt_rdata);
        state_next = S_CMP;
      end

      S_RDATA: begin
        res_char_next = res_bad ? 8'd0 : tx_rdata_a;
        state_next    = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid || out_ready) begin
          out_valid_next           = 1'b1;
          out_data_next.kind       = res_kind;
          out_data_next.out_char   = res_char;
          out_data_next.prefix_len = FIELD_W'(pl_q);
          out_data_next.result_len = FIELD_W'(rlen_q);
          out_data_next.overflow   = ovf_q;
          out_data_next.bad_index  = res_bad;
          state_next               = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      n_q        <= '0;
      pl_q       <= '0;
      ovf_q      <= 1'b0;
      computed_q <= 1'b0;
      rlen_q     <= '0;
      k_q        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      n_q        <= n_next;
      pl_q       <= pl_next;
      ovf_q      <= ovf_next;
      computed_q <= computed_next;
      rlen_q     <= rlen_next;
      k_q        <= k_next;
      out_valid  <= out_valid_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    i_q      <= i_next;
    len_q    <= len_next;
    res_kind <= res_kind_next;
    res_bad  <= res_bad_next;
    res_char <= res_char_next;
    out_data <= out_data_next;
  end

  a_len_below_i: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (POS_W'(len_q) < i_q))
    else $error("prefix length not below scan position");

  a_len_capacity: assert property (@(posedge clk) disable iff (rst)
    n_q <= LEN_W'(MAX_LEN))
    else $error("string length beyond capacity");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("result presented outside the emit step");

endmodule

// File: hw/rtl/shortest_palindrome_kmp.sv
// A plain load leaves the queue in the idle step; a read popped there has its text byte
// registered and captured, then presented from the emit step. A load flagged last
// runs the prefix function over 2n+1 symbols with table fall-backs in one compare loop on the
// text and prefix-table memories. A 4-entry request queue lets input run ahead of the engine.
// Reset (rst, synchronous) clears length, prefix, overflow and handshake state and holds off
// input; the text and prefix-table memories are not cleared and need no clearing pass.
module shortest_palindrome_kmp (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // char_in[7:0], read_index[18:8], zero[23:19]
  input  logic        s_tlast,
  input  logic        s_tuser,  // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // out_char[7:0], prefix_len[18:8], result_len[29:19],
                                // overflow[30], bad_index[31]
  output logic        m_tuser   // kind
);
  import spk_pkg::*;

  qentry_t in_entry;
  qentry_t q_head;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  logic    push;
  result_t res;

  // Front end: classify each request
  always_comb begin
    in_entry.char_in    = s_tdata[7:0];
    in_entry.read_index = s_tdata[18:8];
    if (s_tuser == CMD_READ) begin
      in_entry.op = OP_READ;
    end else if (s_tlast) begin
      in_entry.op = OP_LOAD_LAST;
    end else begin
      in_entry.op = OP_LOAD;
    end
  end

  // no requests taken while in reset
  assign s_tready = !rst && !q_full;
  assign push     = s_tvalid && s_tready;

  spk_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (in_entry),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  spk_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  // Result packing
  assign m_tdata = {res.bad_index, res.overflow, res.result_len, res.prefix_len, res.out_char};
  assign m_tuser = res.kind;

endmodule

// File: sim/tb_shortest_palindrome_kmp.sv
// Self-checking testbench for the shortest-palindrome (KMP prefix function) stream block.
module tb_shortest_palindrome_kmp;
  timeunit 1ns;
  timeprecision 1ps;
  import spk_pkg::*;

  localparam int IDLE_LIMIT = 20000;   // covers the longest engine run, n up to MAX_LEN
  localparam int HOLD_CYCLES = 300;    // one long receiver hold-off
  localparam int SMALL_BUDGET = 800;   // requests before the full-capacity string

  typedef struct {
    logic              cmd;
    logic [7:0]        ch;
    logic              last;
    logic [10:0]       idx;
    bit                typed;
    result_t           want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // char_in[7:0], read_index[18:8], zero[23:19]
  logic        s_tlast;
  logic        s_tuser;   // command
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // out_char[7:0], prefix_len[18:8], result_len[29:19],
                          // overflow[30], bad_index[31]
  logic        m_tuser;   // kind

  shortest_palindrome_kmp dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Palindrome state mirror
  logic [7:0]  str_bytes[MAX_LEN];
  int unsigned pfx_tab[PT_DEPTH];
  int unsigned str_len;
  int unsigned pal_prefix;
  bit          ovf_flag;
  bit          str_done;

  result_t     answers_due[$];
  stim_row_t   dir_rows[$];
  logic [7:0]  gen_bytes[MAX_LEN + 2];

  int  requests_sent;
  int  loads_sent;
  int  reads_sent;
  int  reports_seen;
  int  answers_seen;
  int  bad_seen;
  int  ovf_seen;
  int  mismatches;
  int  unexpected;
  int  idle_cycles;
  int  max_prefix;
  bit  snd_burst;
  bit  rcv_burst;
  bit  held_off;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Symbol p of s, separator, reverse(s); separator is 9-bit 256, never a byte
  function automatic int unsigned kmp_symbol(int unsigned p, int unsigned n);
    if (p < n) return str_bytes[p];
    if (p == n) return 256;
    return str_bytes[(2 * n - p) % MAX_LEN];
  endfunction

  // Longest palindromic prefix via prefix function over s # reverse(s)
  function automatic int unsigned longest_pal_prefix(int unsigned n);
    int unsigned m;
    int unsigned k;
    int unsigned i;
    m = 2 * n + 1;
    k = 0;
    i = 1;
    pfx_tab[0] = 0;
    while (i < m) begin
      if (kmp_symbol(i, n) == kmp_symbol(k, n)) begin
        k++;
        pfx_tab[i] = k;
        i++;
      end else if (k != 0) begin
        k = pfx_tab[k - 1];
      end else begin
        pfx_tab[i] = 0;
        i++;
      end
    end
    return pfx_tab[m - 1];
  endfunction

  function automatic int unsigned palin_result_len();
    return str_done ? (2 * str_len - pal_prefix) : 0;
  endfunction

  // Advance the mirror by one request; returns 1 if the request yields a result
  function automatic bit predict_palindrome(input logic cmd, input logic [7:0] ch,
                                            input logic last, input logic [10:0] idx,
                                            output result_t r);
    int unsigned rlen;
    int unsigned k;
    int unsigned pos;
    r = '0;
    if (cmd == CMD_LOAD) begin
      // first load after a finished string starts a new one
      if (str_done) begin
        str_len = 0;
        pal_prefix = 0;
        ovf_flag = 1'b0;
        str_done = 1'b0;
      end
      if (str_len < MAX_LEN) begin
        str_bytes[str_len] = ch;
        str_len++;
      end else begin
        ovf_flag = 1'b1;
      end
      if (!last) return 1'b0;
      pal_prefix = longest_pal_prefix(str_len);
      str_done = 1'b1;
      r.kind = KIND_LEN;
      r.prefix_len = pal_prefix[10:0];
      r.result_len = 11'(palin_result_len());
      r.overflow = ovf_flag;
      return 1'b1;
    end
    rlen = palin_result_len();
    r.kind = KIND_READ;
    r.prefix_len = pal_prefix[10:0];
    r.result_len = rlen[10:0];
    r.overflow = ovf_flag;
    r.bad_index = 1'b1;
    if (idx < rlen) begin
      k = str_len - pal_prefix;
      pos = (idx < k) ? (str_len - 1 - idx) : (idx - k);
      r.out_char = str_bytes[pos % MAX_LEN];
      r.bad_index = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t row(logic cmd, logic [7:0] ch, logic last, logic [10:0] idx,
                                    bit typed, logic [10:0] pl, logic [10:0] rl, logic bad);
    stim_row_t t;
    t.cmd = cmd;
    t.ch = ch;
    t.last = last;
    t.idx = idx;
    t.typed = typed;
    t.want = '0;
    t.want.kind = (cmd == CMD_READ) ? KIND_READ : KIND_LEN;
    t.want.prefix_len = pl;
    t.want.result_len = rl;
    t.want.bad_index = bad;
    return t;
  endfunction

  // Offer one request, wait for the handshake, queue what it should produce
  task automatic send_request(logic cmd, logic [7:0] ch, logic last, logic [10:0] idx,
                              bit typed, result_t typed_want);
    int gap;
    result_t r;
    if ($urandom_range(0, 39) == 0) snd_burst = ~snd_burst;
    gap = snd_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tlast  <= last;
    s_tdata  <= {5'b0, idx, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    if (cmd == CMD_LOAD) loads_sent++;
    else reads_sent++;
    if (predict_palindrome(cmd, ch, last, idx, r)) begin
      answers_due.push_back(typed ? typed_want : r);
    end
  endtask

  // Read-back burst: mostly in range, some just past the end, some anywhere
  task automatic read_back(int count);
    int unsigned rlen;
    int sel;
    logic [10:0] idx;
    repeat (count) begin
      rlen = palin_result_len();
      sel = $urandom_range(0, 9);
      if (sel < 8 && rlen > 0) idx = 11'($urandom_range(0, rlen - 1));
      else if (sel == 8) idx = 11'(rlen + $urandom_range(0, 2));
      else idx = 11'($urandom_range(0, 2047));
      send_request(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx,
                   1'b0, '0);
    end
  endtask

  // One string: palindromic head of pal_len bytes, rest random; alpha 256 is full range
  task automatic send_string(int n, int pal_len, int alpha, bit noise);
    int i;
    for (i = 0; i < n; i++) begin
      if (i < pal_len && i >= (pal_len + 1) / 2) gen_bytes[i] = gen_bytes[pal_len - 1 - i];
      else if (alpha >= 256) gen_bytes[i] = 8'($urandom_range(0, 255));
      else gen_bytes[i] = 8'(8'h61 + $urandom_range(0, alpha - 1));
    end
    for (i = 0; i < n; i++) begin
      // stray reads while the string is still partial
      if (noise && $urandom_range(0, 9) == 0) read_back(1);
      send_request(CMD_LOAD, gen_bytes[i], i == n - 1, 11'($urandom_range(0, 2047)),
                   1'b0, '0);
    end
  endtask

  // Receiver: random stalls, one long hold-off once traffic is flowing
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0) rcv_burst = ~rcv_burst;
      gap = rcv_burst ? 0 : $urandom_range(0, 12);
      if (!held_off && requests_sent >= 300) begin
        held_off = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind       = m_tuser;
      got.out_char   = m_tdata[7:0];
      got.prefix_len = m_tdata[18:8];
      got.result_len = m_tdata[29:19];
      got.overflow   = m_tdata[30];
      got.bad_index  = m_tdata[31];
      if (answers_due.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result: kind=%0d char=%02h pl=%0d rl=%0d ovf=%0d bad=%0d",
                   got.kind, got.out_char, got.prefix_len, got.result_len,
                   got.overflow, got.bad_index);
      end else begin
        want = answers_due.pop_front();
        if (got.kind == KIND_LEN) reports_seen++;
        else answers_seen++;
        if (got.bad_index) bad_seen++;
        if (got.overflow) ovf_seen++;
        if (int'(got.prefix_len) > max_prefix) max_prefix = int'(got.prefix_len);
        if (got.kind != want.kind || got.out_char != want.out_char ||
            got.prefix_len != want.prefix_len || got.result_len != want.result_len ||
            got.overflow != want.overflow || got.bad_index != want.bad_index) begin
          mismatches++;
          if (mismatches + unexpected <= 10) begin
            $display("mismatch: want kind=%0d char=%02h pl=%0d rl=%0d ovf=%0d bad=%0d",
                     want.kind, want.out_char, want.prefix_len, want.result_len,
                     want.overflow, want.bad_index);
            $display("          got  kind=%0d char=%02h pl=%0d rl=%0d ovf=%0d bad=%0d",
                     got.kind, got.out_char, got.prefix_len, got.result_len,
                     got.overflow, got.bad_index);
          end
        end
      end
    end
  end

  // Watchdog on handshake activity
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no handshake for %0d cycles", IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned rlen;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    s_tuser = CMD_LOAD;
    str_len = 0;
    pal_prefix = 0;
    ovf_flag = 1'b0;
    str_done = 1'b0;
    snd_burst = 1'b0;
    rcv_burst = 1'b0;
    held_off = 1'b0;

    // reads before any string, one-byte string, byte extremes, partial string, fall-backs
    dir_rows.push_back(row(CMD_READ, 8'h00, 1'b0, 11'd0,    1'b1, 11'd0, 11'd0, 1'b1));
    dir_rows.push_back(row(CMD_READ, 8'hFF, 1'b1, 11'd2047, 1'b1, 11'd0, 11'd0, 1'b1));
    dir_rows.push_back(row(CMD_LOAD, 8'h61, 1'b1, 11'd0,    1'b1, 11'd1, 11'd1, 1'b0));
    dir_rows.push_back(row(CMD_READ, 8'h00, 1'b0, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_READ, 8'h00, 1'b0, 11'd1,    1'b1, 11'd1, 11'd1, 1'b1));
    dir_rows.push_back(row(CMD_LOAD, 8'h00, 1'b0, 11'd2047, 1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_LOAD, 8'hFF, 1'b0, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_LOAD, 8'hFF, 1'b1, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_READ, 8'h00, 1'b0, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_READ, 8'h00, 1'b0, 11'd4,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_READ, 8'h00, 1'b0, 11'd5,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_LOAD, 8'h78, 1'b0, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_READ, 8'h00, 1'b0, 11'd0,    1'b1, 11'd0, 11'd0, 1'b1));
    dir_rows.push_back(row(CMD_LOAD, 8'h78, 1'b1, 11'd0,    1'b1, 11'd2, 11'd2, 1'b0));
    dir_rows.push_back(row(CMD_LOAD, 8'h61, 1'b0, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_LOAD, 8'h61, 1'b0, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_LOAD, 8'h63, 1'b0, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_LOAD, 8'h65, 1'b0, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_LOAD, 8'h63, 1'b0, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_LOAD, 8'h61, 1'b0, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_LOAD, 8'h61, 1'b0, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_LOAD, 8'h61, 1'b1, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_READ, 8'h00, 1'b0, 11'd0,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_READ, 8'h00, 1'b0, 11'd8,    1'b0, 11'd0, 11'd0, 1'b0));
    dir_rows.push_back(row(CMD_READ, 8'h00, 1'b0, 11'd9,    1'b0, 11'd0, 11'd0, 1'b0));

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (dir_rows[i])
      send_request(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].last, dir_rows[i].idx,
                   dir_rows[i].typed, dir_rows[i].want);

    // short strings with random content, small alphabets to give long palindromic heads
    while (requests_sent < SMALL_BUDGET) begin : small_strings
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0: send_string(n, 0, 256, 1'b1);
        1: send_string(n, 0, 2, 1'b1);
        2: send_string(n, $urandom_range(1, n), 3, 1'b1);
        default: send_string(n, n, 1, 1'b1);
      endcase
      read_back($urandom_range(0, 2 * n + 3));
    end

    // full capacity plus two dropped bytes, last on a dropped byte
    send_string(MAX_LEN + 2, 700, 256, 1'b0);
    rlen = palin_result_len();
    send_request(CMD_READ, 8'h00, 1'b0, 11'd0, 1'b0, '0);
    send_request(CMD_READ, 8'h00, 1'b0, 11'(rlen - 1), 1'b0, '0);
    send_request(CMD_READ, 8'h00, 1'b0, 11'(rlen), 1'b0, '0);
    send_request(CMD_READ, 8'h00, 1'b0, 11'd2047, 1'b0, '0);
    read_back(16);

    // next string clears the overflow flag
    send_string(5, 3, 2, 1'b0);
    read_back(12);

    @(negedge clk) s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("requests: %0d loads, %0d reads; results: %0d length reports, %0d read answers",
             loads_sent, reads_sent, reports_seen, answers_seen);
    $display("out-of-range answers: %0d, with overflow set: %0d, longest prefix: %0d",
             bad_seen, ovf_seen, max_prefix);
    if (mismatches == 0 && unexpected == 0 && answers_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing",
               mismatches, unexpected, answers_due.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: shortest_palindrome_kmp.f
hw/rtl/spk_pkg.sv
hw/rtl/spk_queue.sv
hw/rtl/spk_engine.sv
hw/rtl/shortest_palindrome_kmp.sv
sim/tb_shortest_palindrome_kmp.sv
